>>> hw/rtl/rrst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Row range tracker package
// Mark and status codes and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package rrst_pkg;

   localparam int IO_ROW_W = 16;

   typedef logic [IO_ROW_W-1:0] io_row_type;
   typedef logic [1:0]          mark_type;
   typedef logic [1:0]          status_type;

   localparam mark_type MARK_BLANK     = 2'd0;
   localparam mark_type MARK_REQUESTED = 2'd1;
   localparam mark_type MARK_LOADED    = 2'd2;

   localparam status_type STATUS_APPLIED = 2'd0;
   localparam status_type STATUS_IGNORED = 2'd1;
   localparam status_type STATUS_FULL    = 2'd2;

endpackage
`default_nettype wire

>>> hw/rtl/rrst_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Row range tracker channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrst_req_if
   import rrst_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       func;
   io_row_type row_from;
   io_row_type row_to;

   modport source (output valid, output func, output row_from, output row_to, input ready);
   modport sink   (input valid, input func, input row_from, input row_to, output ready);
endinterface

interface rrst_rsp_if
   import rrst_pkg::*;
   ();
   logic       valid;
   logic       ready;
   io_row_type range_start;
   io_row_type range_end;
   mark_type   range_mark;
   logic       last_range;
   logic       fully_loaded;
   status_type status;

   modport source (output valid, output range_start, output range_end, output range_mark,
                   output last_range, output fully_loaded, output status, input ready);
   modport sink   (input valid, input range_start, input range_end, input range_mark,
                   input last_range, input fully_loaded, input status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rrst_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range table bank
// One synchronous memory of range entries, one write and one registered read.
// ----------------------------------------------------------------------------
module rrst_bank #(
   parameter int DEPTH  = 32,
   parameter int DATA_W = 34,
   parameter int AW     = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/row_range_state_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Row range state tracker
// Keeps rows 1..total as a sorted partition of marked ranges and repaints it.
// ----------------------------------------------------------------------------
//  Channel   Dir  Carries
//  req       in   func, row_from, row_to: one paint request per item
//  rsp       out  one item per range of the partition, last_range on the final
//  csr       in   total_rows write: one blank range, or an empty table for 0
//
//  A request walks the table twice (left parts, then right parts), one entry
//  a cycle through the memory read port, then streams count results at one a
//  cycle while the response is not stalled. Ignored requests skip the walk.
//  The table sits in two banks: the new partition is built in the other bank
//  and the banks swap only when it fits, so a full table stays unchanged.
//  Reset empties the table; the memories need no clearing.
//  Response stalls hold the stream; requests are taken only in the idle state.
// ----------------------------------------------------------------------------
module row_range_state_tracker
   import rrst_pkg::*;
#(
   parameter int MAX_RANGES = 32,
   parameter int ROW_BITS   = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rrst_req_if.sink        req,
   rrst_rsp_if.source      rsp,
   input  wire logic       csr_we,
   input  wire io_row_type csr_wdata
);

   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int WW = $clog2(MAX_RANGES + 2);
   localparam int EW = 2 * ROW_BITS + 2;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_P1   = 3'd1;
   localparam logic [2:0] S_NEW  = 3'd2;
   localparam logic [2:0] S_P2   = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [ROW_BITS-1:0] total_ff, total_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                sel_ff, sel_in;
   logic [ROW_BITS-1:0] from_ff, from_in, to_ff, to_in;
   mark_type            mark_ff, mark_in;
   status_type          status_ff, status_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]       ld_idx_ff, ld_idx_in;
   logic                pend_ff, pend_in;
   logic                rdsel_ff, rdsel_in;
   logic [ROW_BITS-1:0] acc_s_ff, acc_s_in, acc_e_ff, acc_e_in;
   mark_type            acc_m_ff, acc_m_in;
   logic [WW-1:0]       wcnt_ff, wcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   io_row_type          rsp_start_ff, rsp_start_in, rsp_end_ff, rsp_end_in;
   mark_type            rsp_mark_ff, rsp_mark_in;
   logic                rsp_last_ff, rsp_last_in, rsp_full_ff, rsp_full_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [EW-1:0]       q0, q1, q;
   logic [ROW_BITS-1:0] q_s, q_e;
   mark_type            q_m;
   logic                pw_en, cfg_en;
   logic [AW-1:0]       pw_addr;
   logic [EW-1:0]       pw_data, cfg_data;
   logic                push_en;
   logic [ROW_BITS-1:0] push_s, push_e;
   mark_type            push_m;
   logic [WW-1:0]       wm1;
   logic                can_load, issue;
   logic [ROW_BITS-1:0] in_from, in_to, cfg_total;
   logic [EW-1:0]       bank_q [2];

   assign q   = rdsel_ff ? q1 : q0;
   assign q_s = q[EW-1 -: ROW_BITS];
   assign q_e = q[ROW_BITS+1 -: ROW_BITS];
   assign q_m = q[1:0];
   assign wm1 = wcnt_ff - 1'b1;
   assign in_from   = ROW_BITS'(req.row_from);
   assign in_to     = ROW_BITS'(req.row_to);
   assign cfg_total = ROW_BITS'(csr_wdata);
   assign can_load  = !rsp_valid_ff || rsp.ready;
   assign cfg_data  = {ROW_BITS'(1), cfg_total, MARK_BLANK};
   assign cfg_en    = csr_we && (cfg_total != '0);

   for (genvar b = 0; b < 2; b++) begin : g_bank
      logic          b_we;
      logic [AW-1:0] b_addr;
      logic [EW-1:0] b_data;
      // The current bank takes configuration writes; the other one is rebuilt.
      assign b_we   = (cfg_en && (sel_ff == 1'(b))) || (pw_en && (sel_ff != 1'(b)));
      assign b_addr = cfg_en ? '0 : pw_addr;
      assign b_data = cfg_en ? cfg_data : pw_data;
      rrst_bank #(.DEPTH(MAX_RANGES), .DATA_W(EW), .AW(AW)) u_bank (
         .clock   (clock),
         .wr_en   (b_we),
         .wr_addr (b_addr),
         .wr_data (b_data),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (bank_q[b])
      );
   end
   assign q0 = bank_q[0];
   assign q1 = bank_q[1];

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.range_start  = rsp_start_ff;
   assign rsp.range_end    = rsp_end_ff;
   assign rsp.range_mark   = rsp_mark_ff;
   assign rsp.last_range   = rsp_last_ff;
   assign rsp.fully_loaded = rsp_full_ff;
   assign rsp.status       = rsp_status_ff;

   always_comb begin
      state_in = state_ff;   total_in = total_ff;   count_in = count_ff;
      sel_in = sel_ff;       from_in = from_ff;     to_in = to_ff;
      mark_in = mark_ff;     status_in = status_ff; rd_idx_in = rd_idx_ff;
      ld_idx_in = ld_idx_ff; pend_in = pend_ff;     rdsel_in = rdsel_ff;
      acc_s_in = acc_s_ff;   acc_e_in = acc_e_ff;   acc_m_in = acc_m_ff;
      wcnt_in = wcnt_ff;
      rsp_valid_in = rsp_valid_ff; rsp_start_in = rsp_start_ff; rsp_end_in = rsp_end_ff;
      rsp_mark_in = rsp_mark_ff;   rsp_last_in = rsp_last_ff;   rsp_full_in = rsp_full_ff;
      rsp_status_in = rsp_status_ff;
      rd_en = 1'b0;  rd_addr = rd_idx_ff[AW-1:0];
      pw_en = 1'b0;  pw_addr = wm1[AW-1:0];  pw_data = {acc_s_ff, acc_e_ff, acc_m_ff};
      push_en = 1'b0; push_s = from_ff; push_e = to_ff; push_m = mark_ff;
      issue = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               from_in   = in_from;
               to_in     = in_to;
               mark_in   = req.func ? MARK_LOADED : MARK_REQUESTED;
               rd_idx_in = '0;
               ld_idx_in = '0;
               pend_in   = 1'b0;
               wcnt_in   = '0;
               if ((in_from != '0) && (in_from <= in_to) && (in_to <= total_ff)
                   && (count_ff != '0)) begin
                  status_in = STATUS_APPLIED;
                  state_in  = S_P1;
               end else begin
                  status_in = STATUS_IGNORED;
                  state_in  = S_EMIT;
               end
            end
         end
         S_P1, S_P2: begin
            issue = (rd_idx_ff < count_ff);
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               rdsel_in  = sel_ff;
            end
            pend_in = issue;
            if (pend_ff) begin
               if (state_ff == S_P1) begin
                  // Part of the entry left of the painted rows.
                  push_en = (q_s < from_ff);
                  push_s  = q_s;
                  push_e  = (q_e < (from_ff - 1'b1)) ? q_e : (from_ff - 1'b1);
               end else begin
                  // Part of the entry right of the painted rows.
                  push_en = (q_e > to_ff);
                  push_s  = (q_s > to_ff) ? q_s : (to_ff + 1'b1);
                  push_e  = q_e;
               end
               push_m = q_m;
            end
            if (!issue && !pend_ff) begin
               rd_idx_in = '0;
               state_in  = (state_ff == S_P1) ? S_NEW : S_FIN;
            end
         end
         S_NEW: begin
            push_en  = 1'b1;
            state_in = S_P2;
         end
         S_FIN: begin
            if (wcnt_ff <= WW'(MAX_RANGES)) begin
               pw_en     = 1'b1;
               count_in  = CW'(wcnt_ff);
               sel_in    = !sel_ff;
               status_in = STATUS_APPLIED;
            end else begin
               status_in = STATUS_FULL;
            end
            rd_idx_in = '0;
            ld_idx_in = '0;
            pend_in   = 1'b0;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (count_ff == '0) begin
               if (can_load) begin
                  rsp_valid_in  = 1'b1;
                  rsp_start_in  = '0;
                  rsp_end_in    = '0;
                  rsp_mark_in   = MARK_BLANK;
                  rsp_last_in   = 1'b1;
                  rsp_full_in   = 1'b0;
                  rsp_status_in = status_ff;
                  state_in      = S_IDLE;
               end
            end else begin
               issue = (rd_idx_ff < count_ff) && (!pend_ff || can_load);
               if (pend_ff && can_load) begin
                  rsp_valid_in  = 1'b1;
                  rsp_start_in  = IO_ROW_W'(q_s);
                  rsp_end_in    = IO_ROW_W'(q_e);
                  rsp_mark_in   = q_m;
                  rsp_last_in   = (ld_idx_ff == (count_ff - 1'b1));
                  rsp_full_in   = (count_ff == CW'(1)) && (q_m == MARK_LOADED);
                  rsp_status_in = status_ff;
                  ld_idx_in     = ld_idx_ff + 1'b1;
                  if (ld_idx_ff == (count_ff - 1'b1)) begin
                     state_in = S_IDLE;
                  end
               end
               if (issue) begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + 1'b1;
                  rdsel_in  = sel_ff;
                  pend_in   = 1'b1;
               end else if (can_load) begin
                  pend_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Append to the new partition, merging with an equal-marked predecessor.
      // The open entry is written out when a different mark follows it or the walk ends.
      if (push_en) begin
         if ((wcnt_ff != '0) && (acc_m_ff == push_m)) begin
            acc_e_in = push_e;
         end else begin
            if ((wcnt_ff != '0) && (wcnt_ff <= WW'(MAX_RANGES))) begin
               pw_en = 1'b1;
            end
            acc_s_in = push_s;
            acc_e_in = push_e;
            acc_m_in = push_m;
            if (wcnt_ff != WW'(MAX_RANGES + 1)) begin
               wcnt_in = wcnt_ff + 1'b1;
            end
         end
      end

      if (csr_we) begin
         total_in = cfg_total;
         count_in = (cfg_total == '0) ? '0 : CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         count_ff     <= '0;
         sel_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         sel_ff       <= sel_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         wcnt_ff      <= wcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff       <= from_in;
      to_ff         <= to_in;
      mark_ff       <= mark_in;
      status_ff     <= status_in;
      rd_idx_ff     <= rd_idx_in;
      ld_idx_ff     <= ld_idx_in;
      rdsel_ff      <= rdsel_in;
      acc_s_ff      <= acc_s_in;
      acc_e_ff      <= acc_e_in;
      acc_m_ff      <= acc_m_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_mark_ff   <= rsp_mark_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
`default_nettype wire

>>> bench/row_range_state_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row range tracker checker
// Watches the request, response and register ports, keeps its own copy of
// the range partition, and compares every response item with the expected one.
// ----------------------------------------------------------------------------
module row_range_state_tracker_checker
   import rrst_pkg::*;
#(
   parameter int MAX_RANGES = 32
) (
   input  logic       clock,
   input  logic       reset,
   rrst_req_if        req,
   rrst_rsp_if        rsp,
   input  logic       csr_we,
   input  io_row_type csr_wdata,
   output int         errors,
   output int         pending,
   output int         checked
);

   typedef struct packed {
      io_row_type first_row;
      io_row_type last_row;
      mark_type   mark;
      logic       last_flag;
      logic       all_loaded;
      status_type status;
   } range_item_t;

   range_item_t range_q[$];

   int unsigned table_rows;
   int unsigned part_first [MAX_RANGES];
   int unsigned part_last  [MAX_RANGES];
   mark_type    part_mark  [MAX_RANGES];
   int unsigned part_count;

   int unsigned wk_first [MAX_RANGES+2];
   int unsigned wk_last  [MAX_RANGES+2];
   mark_type    wk_mark  [MAX_RANGES+2];
   int unsigned wk_count;

   // Appends to the new partition, merging into an equal-marked predecessor.
   function automatic void stage(int unsigned s, int unsigned e, mark_type m);
      if (wk_count > 0 && wk_mark[wk_count-1] == m) begin
         wk_last[wk_count-1] = e;
      end else if (wk_count < MAX_RANGES + 2) begin
         wk_first[wk_count] = s;
         wk_last[wk_count]  = e;
         wk_mark[wk_count]  = m;
         wk_count++;
      end
   endfunction

   function automatic status_type repaint(int unsigned from, int unsigned to, mark_type m);
      if (from < 1 || from > to || to > table_rows || part_count == 0)
         return STATUS_IGNORED;
      wk_count = 0;
      for (int i = 0; i < part_count; i++) begin
         if (part_first[i] < from)
            stage(part_first[i], (part_last[i] < from - 1) ? part_last[i] : from - 1,
                  part_mark[i]);
      end
      stage(from, to, m);
      for (int i = 0; i < part_count; i++) begin
         if (part_last[i] > to)
            stage((part_first[i] > to + 1) ? part_first[i] : to + 1, part_last[i],
                  part_mark[i]);
      end
      if (wk_count > MAX_RANGES)
         return STATUS_FULL;
      for (int i = 0; i < wk_count; i++) begin
         part_first[i] = wk_first[i];
         part_last[i]  = wk_last[i];
         part_mark[i]  = wk_mark[i];
      end
      part_count = wk_count;
      return STATUS_APPLIED;
   endfunction

   function automatic void predict_ranges(logic func, io_row_type from, io_row_type to);
      status_type  st;
      logic        full;
      range_item_t it;
      st   = repaint(32'(from), 32'(to), func ? MARK_LOADED : MARK_REQUESTED);
      full = (part_count == 1 && part_mark[0] == MARK_LOADED);
      if (part_count == 0) begin
         it = '{first_row: '0, last_row: '0, mark: MARK_BLANK, last_flag: 1'b1,
                all_loaded: 1'b0, status: st};
         range_q.insert(range_q.size(), it);
      end else begin
         for (int i = 0; i < part_count; i++) begin
            it.first_row  = io_row_type'(part_first[i]);
            it.last_row   = io_row_type'(part_last[i]);
            it.mark       = part_mark[i];
            it.last_flag  = (i + 1 == part_count);
            it.all_loaded = full;
            it.status     = st;
            range_q.insert(range_q.size(), it);
         end
      end
   endfunction

   always @(posedge clock) begin
      range_item_t got, want;
      if (reset) begin
         table_rows = 0;
         part_count = 0;
         errors     = 0;
         checked    = 0;
         range_q.delete();
      end else begin
         if (csr_we) begin
            table_rows = 32'(csr_wdata);
            if (table_rows == 0) begin
               part_count = 0;
            end else begin
               part_first[0] = 1;
               part_last[0]  = table_rows;
               part_mark[0]  = MARK_BLANK;
               part_count    = 1;
            end
         end
         if (req.valid && req.ready)
            predict_ranges(req.func, req.row_from, req.row_to);
         if (rsp.valid && rsp.ready) begin
            got = '{first_row: rsp.range_start, last_row: rsp.range_end,
                    mark: rsp.range_mark, last_flag: rsp.last_range,
                    all_loaded: rsp.fully_loaded, status: rsp.status};
            checked++;
            if (range_q.size() == 0) begin
               if (errors < 10)
                  $display("ERROR: response item with nothing expected: %p", got);
               errors++;
            end else begin
               want = range_q.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display("ERROR: range mismatch\n  expected %p\n  actual   %p", want, got);
                  errors++;
               end
            end
         end
      end
      pending = range_q.size();
   end

endmodule

>>> bench/row_range_state_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row range state tracker testbench
// Drives paint requests and row count writes under random idling and a long
// response stall; a checker beside the block predicts every range item.
// ----------------------------------------------------------------------------
module row_range_state_tracker_tb;
   import rrst_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   io_row_type csr_wdata = '0;

   int errors, pending, checked;
   int tx_idle = 34;
   int rx_idle = 71;
   int rx_hold = 0;
   int items_sent = 0;

   rrst_req_if req_ch ();
   rrst_rsp_if rsp_ch ();

   row_range_state_tracker DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   row_range_state_tracker_checker CHK (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending),
      .checked   (checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver; a hold request keeps ready low until its count runs out.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rx_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rx_hold--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   task automatic send_paint(logic f, int unsigned from, int unsigned to);
      if ($urandom_range(99) < tx_idle) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= f;
      req_ch.row_from <= io_row_type'(from);
      req_ch.row_to   <= io_row_type'(to);
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Lowers valid at the acceptance edge, then waits until the block is idle.
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_rows(int unsigned n);
      drain();
      csr_wdata <= io_row_type'(n);
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_paint(int unsigned total);
      int unsigned a, b, d;
      if ($urandom_range(9) == 0) begin
         send_paint(1'($urandom_range(1)), $urandom_range(65535), $urandom_range(65535));
      end else begin
         a = $urandom_range(1, total);
         d = $urandom_range(0, 8);
         if ($urandom_range(3) == 0)
            b = $urandom_range(a, total);
         else
            b = (a + d > total) ? total : a + d;
         send_paint(1'($urandom_range(1)), a, b);
      end
   endtask

   initial begin
      int unsigned rows;
      req_ch.valid    <= 1'b0;
      req_ch.func     <= 1'b0;
      req_ch.row_from <= '0;
      req_ch.row_to   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table right after reset.
      send_paint(1'b1, 1, 1);
      write_rows(1);
      send_paint(1'b1, 1, 1);
      send_paint(1'b0, 0, 0);
      write_rows(65535);
      send_paint(1'b0, 1, 65535);
      send_paint(1'b1, 0, 5);
      send_paint(1'b1, 9, 8);
      send_paint(1'b0, 65535, 65535);
      send_paint(1'b1, 1, 1);
      send_paint(1'b1, 32768, 40000);
      // Isolated single rows fill the table until a request is rejected.
      write_rows(64);
      for (int unsigned r = 1; r <= 33; r += 2)
         send_paint(1'b1, r, r);
      write_rows(0);

      for (int p = 0; p < 3; p++) begin
         tx_idle = (p == 0) ? 34 : (p == 1) ? 71 : 0;
         rx_idle = (p == 0) ? 71 : (p == 1) ? 34 : 0;
         for (int k = 0; k < 4; k++) begin
            rows = (k == 0) ? 65535 : (k == 1) ? 40 : (k == 2) ?
                   $urandom_range(2, 500) : 12;
            write_rows(rows);
            if (p == 2 && k == 1) begin
               @(posedge clock);
               rx_hold = 400;
            end
            repeat (17) random_paint(rows);
         end
      end

      drain();
      $display("Sent %0d paint items over empty, tiny, mid and full-width tables;",
               items_sent);
      $display("checked %0d range items, including rejected and ignored requests.",
               checked);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/rrst_pkg.sv
hw/rtl/rrst_if.sv
hw/rtl/rrst_bank.sv
hw/rtl/row_range_state_tracker.sv
bench/row_range_state_tracker_checker.sv
bench/row_range_state_tracker_tb.sv
